// ===== rtl/walt_pkg.sv =====
// Shared types, codes and helpers of the weekly alarm table.
// No dependencies; imported by weekly_alarm_table_core.
package walt_pkg;

  // request modes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_TEST   = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_FIRE  = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_GLOBAL_EN   = 2'd0;
  localparam logic [1:0] REG_QUIET_EN    = 2'd1;
  localparam logic [1:0] REG_QUIET_START = 2'd2;
  localparam logic [1:0] REG_QUIET_END   = 2'd3;

  localparam logic [10:0] QUIET_START_RST = 11'd1320;
  localparam logic [10:0] QUIET_END_RST   = 11'd420;
  localparam logic [13:0] MIN_PER_DAY     = 14'd1440;
  localparam int          DAYS_AHEAD      = 8;
  localparam logic [6:0]  VOL_MAX         = 7'd100;

  typedef struct packed {
    logic       enabled;
    logic [6:0] days;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       sound;
    logic [6:0] volume;
  } slot_entry_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fired_slot;
    logic       play_sound;
    logic [6:0] volume;
    logic [2:0] day_offset;
    logic [4:0] event_hour;
    logic [5:0] event_minute;
  } result_t;

  // hour * 60 + minute, no wrap; fits 11 bits for any stored bits
  function automatic logic [10:0] minute_of_day(input logic [4:0] h, input logic [5:0] m);
    logic [10:0] h_ext;
    h_ext = {6'b0, h};
    return (h_ext << 6) - (h_ext << 2) + {5'b0, m};
  endfunction

  function automatic logic [6:0] clamp_volume(input logic [6:0] v);
    return (v > VOL_MAX) ? VOL_MAX : v;
  endfunction

endpackage

// ===== rtl/weekly_alarm_table_core.sv =====
// Weekly alarm table: slot storage, minute-tick matcher and next-event search.
// Depends on walt_pkg (codes, entry and result types, helpers).
//
// Every request is taken while in_ready is high. Write and remove complete
// at acceptance and give no result. A tick with global enable on and a valid
// weekday walks the table one slot per cycle, unless a second hit stalls it,
// through the single entry read port; a tick that fires several slots holds the
// newest hit in a pending register and only releases the one before it once
// the output register is free, so a stalled consumer stretches the walk. A
// next-event query walks DAYS_AHEAD days times SLOT_COUNT slots through the same
// port and compare unit. The block takes no new request while a walk or a
// pending result is in flight, but it does accept one while the last result
// still waits in the output register. Configuration registers are written
// through cfg_we.
module weekly_alarm_table_core #(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [2:0]  day_of_week,
  input  logic [4:0]  now_hour,
  input  logic [5:0]  now_minute,
  input  logic [15:0] day_count,
  input  logic [3:0]  slot,
  input  logic        entry_enabled,
  input  logic [6:0]  entry_days,
  input  logic [4:0]  entry_hour,
  input  logic [5:0]  entry_minute,
  input  logic        entry_has_sound,
  input  logic [6:0]  entry_volume,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [3:0]  fired_slot,
  output logic        play_sound,
  output logic [6:0]  volume,
  output logic [2:0]  day_offset,
  output logic [4:0]  event_hour,
  output logic [5:0]  event_minute,
  output logic        last,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import walt_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_TICK, S_TEST, S_QUERY, S_QDONE, S_FLUSH
  } state_t;

  state_t state;

  // configuration registers
  logic        global_enable, quiet_enable;
  logic [10:0] quiet_start, quiet_end;

  // slot table and fired stamps
  slot_entry_t entries [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [SLOT_COUNT-1:0] stamp_valid;
  logic [26:0] fired_stamp [SLOT_COUNT];

  // latched request
  logic [4:0]  now_hour_q;
  logic [5:0]  now_minute_q;
  logic [10:0] now_mod;
  logic [26:0] stamp_q;

  // walk registers
  logic [IDX_W-1:0] idx;
  logic [2:0]  dbit;
  logic [2:0]  off;
  logic [13:0] base;
  logic        found;
  logic [13:0] best;
  logic [3:0]  best_slot;
  logic [2:0]  best_off;
  logic [4:0]  best_hour;
  logic [5:0]  best_minute;

  // pending and output results
  logic    pend_valid;
  result_t pend;
  result_t out_q;
  logic    out_last;

  // request decode
  logic [6:0]       slot_ext;
  logic             slot_in_range;
  logic [IDX_W-1:0] slot_addr;
  logic             dow_ok;
  logic             accept;

  assign accept        = in_valid && in_ready;
  assign slot_ext      = {3'b000, slot};
  assign slot_in_range = slot_ext < 7'(SLOT_COUNT);
  assign slot_addr     = slot_ext[IDX_W-1:0];
  assign dow_ok        = (day_of_week != 3'd0);

  // single read port, addressed by the walk index
  slot_entry_t ent;
  logic        ent_live;
  logic        day_hit;
  logic [13:0] cand;

  assign ent      = entries[idx];
  assign ent_live = slot_valid[idx] && ent.enabled;
  assign day_hit  = ent.days[dbit];
  assign cand     = base + 14'(minute_of_day(ent.hour, ent.minute));

  // quiet window, wrapping past midnight when start > end
  logic in_quiet;
  always_comb begin
    if (!quiet_enable) begin
      in_quiet = 1'b0;
    end else if (quiet_start <= quiet_end) begin
      in_quiet = (now_mod >= quiet_start) && (now_mod < quiet_end);
    end else begin
      in_quiet = (now_mod >= quiet_start) || (now_mod < quiet_end);
    end
  end

  result_t fire_res;
  always_comb begin
    fire_res            = '0;
    fire_res.kind       = KIND_FIRE;
    fire_res.fired_slot = 4'(idx);
    fire_res.play_sound = ent.sound && !in_quiet;
    fire_res.volume     = clamp_volume(ent.volume);
  end

  logic tick_hit, q_hit, out_free, tick_stall, out_load;
  assign tick_hit = ent_live && day_hit && (ent.hour == now_hour_q) &&
                    (ent.minute == now_minute_q) &&
                    !(stamp_valid[idx] && (fired_stamp[idx] == stamp_q));
  assign q_hit    = ent_live && day_hit && (cand > 14'(now_mod)) &&
                    (!found || (cand < best));
  assign out_free = !out_valid || out_ready;
  // a second hit needs the output register to take the held one
  assign tick_stall = tick_hit && pend_valid && !out_free;
  // the output register takes a new result this cycle
  assign out_load = ((state == S_TICK) && tick_hit && pend_valid && out_free) ||
                    ((state == S_FLUSH) && pend_valid && out_free);

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      global_enable <= 1'b1;
      quiet_enable  <= 1'b0;
      quiet_start   <= QUIET_START_RST;
      quiet_end     <= QUIET_END_RST;
      slot_valid    <= '0;
      stamp_valid   <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_GLOBAL_EN:   global_enable <= cfg_data[0];
          REG_QUIET_EN:    quiet_enable  <= cfg_data[0];
          REG_QUIET_START: quiet_start   <= cfg_data;
          REG_QUIET_END:   quiet_end     <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now_hour_q   <= now_hour;
            now_minute_q <= now_minute;
            now_mod      <= minute_of_day(now_hour, now_minute);
            stamp_q      <= {day_count, minute_of_day(now_hour, now_minute)};
            dbit         <= day_of_week - 3'd1;
            off          <= '0;
            base         <= '0;
            found        <= 1'b0;
            // a test reads its own slot, every walk starts at slot zero
            idx          <= (mode == MODE_TEST) ? slot_addr : '0;
            case (mode)
              MODE_TICK: begin
                if (global_enable && dow_ok) begin
                  state <= S_TICK;
                end
              end
              MODE_WRITE: begin
                if (slot_in_range) begin
                  slot_valid[slot_addr] <= 1'b1;
                  entries[slot_addr]    <= '{enabled: entry_enabled, days: entry_days,
                                             hour: entry_hour, minute: entry_minute,
                                             sound: entry_has_sound,
                                             volume: entry_volume};
                end
              end
              MODE_REMOVE: begin
                if (slot_in_range) begin
                  slot_valid[slot_addr]  <= 1'b0;
                  stamp_valid[slot_addr] <= 1'b0;
                end
              end
              MODE_TEST: begin
                if (slot_in_range) begin
                  state <= S_TEST;
                end
              end
              MODE_QUERY: begin
                // no valid weekday: answer straight away with no event
                state <= dow_ok ? S_QUERY : S_QDONE;
              end
              default: ;
            endcase
          end
        end

        S_TICK: begin
          if (!tick_stall) begin
            if (tick_hit) begin
              if (pend_valid) begin
                out_q     <= pend;
                out_last  <= 1'b0;
                out_valid <= 1'b1;
              end
              pend             <= fire_res;
              pend_valid       <= 1'b1;
              stamp_valid[idx] <= 1'b1;
              fired_stamp[idx] <= stamp_q;
            end
            if (idx == IDX_LAST) begin
              state <= S_FLUSH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        S_TEST: begin
          // a test fires even a disabled slot and leaves its stamp alone
          if (slot_valid[idx]) begin
            pend       <= fire_res;
            pend_valid <= 1'b1;
            state      <= S_FLUSH;
          end else begin
            state <= S_IDLE;
          end
        end

        S_QUERY: begin
          if (q_hit) begin
            found       <= 1'b1;
            best        <= cand;
            best_slot   <= 4'(idx);
            best_off    <= off;
            best_hour   <= ent.hour;
            best_minute <= ent.minute;
          end
          if (idx == IDX_LAST) begin
            idx  <= '0;
            off  <= off + 3'd1;
            base <= base + MIN_PER_DAY;
            dbit <= (dbit == 3'd6) ? 3'd0 : dbit + 3'd1;
            if (off == 3'(DAYS_AHEAD - 1)) begin
              state <= S_QDONE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_QDONE: begin
          if (found) begin
            pend <= '{kind: KIND_EVENT, fired_slot: best_slot, play_sound: 1'b0,
                      volume: 7'd0, day_offset: best_off, event_hour: best_hour,
                      event_minute: best_minute};
          end else begin
            pend <= '{kind: KIND_NONE, fired_slot: 4'd0, play_sound: 1'b0,
                      volume: 7'd0, day_offset: 3'd0, event_hour: 5'd0,
                      event_minute: 6'd0};
          end
          pend_valid <= 1'b1;
          state      <= S_FLUSH;
        end

        S_FLUSH: begin
          // release the held result as the final one of this request
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_q      <= pend;
            out_last   <= 1'b1;
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign kind         = out_q.kind;
  assign fired_slot   = out_q.fired_slot;
  assign play_sound   = out_q.play_sound;
  assign volume       = out_q.volume;
  assign day_offset   = out_q.day_offset;
  assign event_hour   = out_q.event_hour;
  assign event_minute = out_q.event_minute;
  assign last         = out_last;

  // nothing stays held once the sequencer is back at rest
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending result left behind in idle");

  // a tick while alarms are globally off must not start a walk
  a_tick_gated: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_TICK) && !global_enable) |=> (state == S_IDLE))
    else $error("tick walked the table with global enable off");

  // a query answer is always the final result of its request
  a_query_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_q.kind != KIND_FIRE)) |-> out_last)
    else $error("query result not marked last");

  // fired volume never exceeds the clamp
  a_vol_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_q.kind == KIND_FIRE)) |-> (out_q.volume <= VOL_MAX))
    else $error("fired volume above clamp");

endmodule

// ===== tb/weekly_alarm_table_core_tb.sv =====
// Self-checking testbench for weekly_alarm_table_core: an in-order scoreboard keeps its own
// copy of the slot table, fired stamps and quiet window and checks every result.
// Depends on walt_pkg and rtl/weekly_alarm_table_core.sv; reads no files.
module weekly_alarm_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import walt_pkg::*;

  localparam int SLOTS           = 16;
  localparam int LOOKAHEAD_DAYS  = 8;
  localparam int MINUTES_PER_DAY = 1440;
  // drain margin covers the longest walk, the next-event search, rounded up
  localparam int DRAIN_CYCLES    = 140;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTS     = 40;

  // one request as offered on the input channel
  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  dow;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] day_count;
    logic [3:0]  slot;
    slot_entry_t entry;
  } request_t;

  // one result as seen on the output channel, in port order
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fired_slot;
    logic       play_sound;
    logic [6:0] volume;
    logic [2:0] day_offset;
    logic [4:0] event_hour;
    logic [5:0] event_minute;
    logic       last;
  } alarm_t;

  // Scoreboard: mirrors the alarm table, works out the alarms each request raises
  // and compares them, in order, with what the block delivers.
  class alarm_scoreboard;
    bit          global_on;
    bit          quiet_on;
    bit [10:0]   quiet_from;
    bit [10:0]   quiet_to;
    bit          in_use[SLOTS];
    slot_entry_t entry[SLOTS];
    bit          stamped[SLOTS];
    bit [26:0]   stamp[SLOTS];
    alarm_t      awaited[$];
    int          errors;
    int          requests;
    int          firings;
    int          events;
    int          empties;

    function new();
      global_on  = 1'b1;
      quiet_on   = 1'b0;
      quiet_from = QUIET_START_RST;
      quiet_to   = QUIET_END_RST;
      foreach (in_use[i]) begin
        in_use[i]  = 1'b0;
        stamped[i] = 1'b0;
        entry[i]   = '0;
        stamp[i]   = '0;
      end
    endfunction

    function void set_register(logic [1:0] idx, logic [10:0] val);
      case (idx)
        REG_GLOBAL_EN:   global_on  = val[0];
        REG_QUIET_EN:    quiet_on   = val[0];
        REG_QUIET_START: quiet_from = val;
        REG_QUIET_END:   quiet_to   = val;
        default: ;
      endcase
    endfunction

    function bit in_quiet(int t);
      if (!quiet_on) return 1'b0;
      if (quiet_from <= quiet_to) return t >= quiet_from && t < quiet_to;
      return t >= quiet_from || t < quiet_to;
    endfunction

    function alarm_t firing(int s, int now, bit final_one);
      alarm_t a;
      a            = '0;
      a.kind       = KIND_FIRE;
      a.fired_slot = 4'(s);
      a.play_sound = entry[s].sound && !in_quiet(now);
      a.volume     = (entry[s].volume > VOL_MAX) ? VOL_MAX : entry[s].volume;
      a.last       = final_one;
      return a;
    endfunction

    function void note_request(request_t q);
      int        now;
      int        cand;
      int        best;
      int        best_slot;
      int        best_off;
      int        day_bit;
      bit        found;
      bit [26:0] tag;
      int        hits[$];
      alarm_t    a;
      now = int'(q.hour) * 60 + int'(q.minute);
      requests++;
      case (q.mode)
        MODE_TICK: begin
          tag = {q.day_count, 11'(now)};
          if (global_on && q.dow != 3'd0) begin
            for (int i = 0; i < SLOTS; i++)
              if (in_use[i] && entry[i].enabled && entry[i].days[q.dow - 3'd1] &&
                  entry[i].hour == q.hour && entry[i].minute == q.minute &&
                  !(stamped[i] && stamp[i] == tag)) begin
                stamped[i] = 1'b1;
                stamp[i]   = tag;
                hits.push_back(i);
              end
            foreach (hits[k]) awaited.push_back(firing(hits[k], now, k == hits.size() - 1));
            firings += hits.size();
          end
        end
        MODE_WRITE: begin
          in_use[q.slot] = 1'b1;
          entry[q.slot]  = q.entry;
        end
        MODE_REMOVE: begin
          in_use[q.slot]  = 1'b0;
          stamped[q.slot] = 1'b0;
        end
        MODE_TEST: begin
          if (in_use[q.slot]) begin
            awaited.push_back(firing(int'(q.slot), now, 1'b1));
            firings++;
          end
        end
        MODE_QUERY: begin
          found     = 1'b0;
          best      = 0;
          best_slot = 0;
          best_off  = 0;
          if (q.dow != 3'd0)
            for (int off = 0; off < LOOKAHEAD_DAYS; off++) begin
              day_bit = (int'(q.dow) - 1 + off) % 7;
              for (int i = 0; i < SLOTS; i++) begin
                cand = off * MINUTES_PER_DAY + int'(entry[i].hour) * 60 + int'(entry[i].minute);
                if (in_use[i] && entry[i].enabled && entry[i].days[day_bit] && cand > now &&
                    (!found || cand < best)) begin
                  found     = 1'b1;
                  best      = cand;
                  best_slot = i;
                  best_off  = off;
                end
              end
            end
          a      = '0;
          a.last = 1'b1;
          if (found) begin
            a.kind         = KIND_EVENT;
            a.fired_slot   = 4'(best_slot);
            a.day_offset   = 3'(best_off);
            a.event_hour   = entry[best_slot].hour;
            a.event_minute = entry[best_slot].minute;
            events++;
          end else begin
            a.kind = KIND_NONE;
            empties++;
          end
          awaited.push_back(a);
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want === got) return;
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(alarm_t got);
      alarm_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing awaited: expected none, got kind %0d slot %0d",
                   $time, got.kind, got.fired_slot);
        return;
      end
      want = awaited.pop_front();
      compare("kind", 16'(want.kind), 16'(got.kind));
      compare("fired_slot", 16'(want.fired_slot), 16'(got.fired_slot));
      compare("play_sound", 16'(want.play_sound), 16'(got.play_sound));
      compare("volume", 16'(want.volume), 16'(got.volume));
      compare("day_offset", 16'(want.day_offset), 16'(got.day_offset));
      compare("event_hour", 16'(want.event_hour), 16'(got.event_hour));
      compare("event_minute", 16'(want.event_minute), 16'(got.event_minute));
      compare("last", 16'(want.last), 16'(got.last));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // clock, reset and every block input start at a known value
  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [2:0]  mode            = '0;
  logic [2:0]  day_of_week     = '0;
  logic [4:0]  now_hour        = '0;
  logic [5:0]  now_minute      = '0;
  logic [15:0] day_count       = '0;
  logic [3:0]  slot            = '0;
  logic        entry_enabled   = 1'b0;
  logic [6:0]  entry_days      = '0;
  logic [4:0]  entry_hour      = '0;
  logic [5:0]  entry_minute    = '0;
  logic        entry_has_sound = 1'b0;
  logic [6:0]  entry_volume    = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  fired_slot;
  logic        play_sound;
  logic [6:0]  volume;
  logic [2:0]  day_offset;
  logic [4:0]  event_hour;
  logic [5:0]  event_minute;
  logic        last;
  logic        cfg_we          = 1'b0;
  logic [1:0]  cfg_index       = '0;
  logic [10:0] cfg_data        = '0;

  alarm_scoreboard sb = new();

  int        send_idle  = 0;   // percent of cycles the sender holds back
  int        recv_idle  = 0;   // percent of cycles the receiver holds back
  int        hold_req   = 0;   // long receiver stall, handed over at a falling edge
  int        hold_left  = 0;
  int        cycles     = 0;
  int        cfg_writes = 0;
  bit [15:0] dc_base    = 16'd100;

  always #6 clk = ~clk;

  weekly_alarm_table_core #(.SLOT_COUNT(SLOTS)) uut (.*);

  // Abort a hung run; the limit is far above the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results awaited", cycles, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: check each accepted result against the oldest awaited one, then pick
  // the next ready value. A long hold-off overrides the random stalling while it runs.
  always @(posedge clk) begin : take_results
    alarm_t got;
    if (!rst && out_valid && out_ready) begin
      got = {kind, fired_slot, play_sound, volume, day_offset, event_hour, event_minute, last};
      sb.check_result(got);
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one request, with random gaps first, and hold it until the block takes it.
  // Leaves in_valid high: the caller's next drive decides whether it drops.
  task automatic send(request_t q);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    mode            <= q.mode;
    day_of_week     <= q.dow;
    now_hour        <= q.hour;
    now_minute      <= q.minute;
    day_count       <= q.day_count;
    slot            <= q.slot;
    entry_enabled   <= q.entry.enabled;
    entry_days      <= q.entry.days;
    entry_hour      <= q.entry.hour;
    entry_minute    <= q.entry.minute;
    entry_has_sound <= q.entry.sound;
    entry_volume    <= q.entry.volume;
    do @(posedge clk); while (!in_ready);
    sb.note_request(q);
  endtask

  // Drop valid and wait for every awaited result, then let any silent walk finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Change idling only at a falling edge so the receiver never races the update.
  task automatic set_idling(int s, int r);
    @(negedge clk);
    send_idle = s;
    recv_idle = r;
    @(posedge clk);
  endtask

  task automatic hold_results(int n);
    @(negedge clk);
    hold_req = n;
    @(posedge clk);
  endtask

  // Leaves cfg_we high; set_config lowers it after the last register.
  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_register(idx, val);
    cfg_writes++;
  endtask

  // Only called with the block idle, after drain().
  task automatic set_config(bit g, bit qe, logic [10:0] qs, logic [10:0] qend);
    write_reg(REG_GLOBAL_EN, 11'(g));
    write_reg(REG_QUIET_EN, 11'(qe));
    write_reg(REG_QUIET_START, qs);
    write_reg(REG_QUIET_END, qend);
    cfg_we <= 1'b0;
  endtask

  function automatic request_t mk(logic [2:0] m, logic [2:0] dow, logic [4:0] h,
                                  logic [5:0] mi, logic [15:0] dc, logic [3:0] s);
    request_t q;
    q           = '0;
    q.mode      = m;
    q.dow       = dow;
    q.hour      = h;
    q.minute    = mi;
    q.day_count = dc;
    q.slot      = s;
    return q;
  endfunction

  function automatic request_t wr(logic [3:0] s, logic en, logic [6:0] days, logic [4:0] h,
                                  logic [5:0] mi, logic snd, logic [6:0] vol);
    request_t q;
    q              = mk(MODE_WRITE, 3'd1, 5'd0, 6'd0, 16'd0, s);
    q.entry.enabled = en;
    q.entry.days    = days;
    q.entry.hour    = h;
    q.entry.minute  = mi;
    q.entry.sound   = snd;
    q.entry.volume  = vol;
    return q;
  endfunction

  // Random request, weighted towards ticks aimed at a live slot so that firings,
  // stamp repeats and multi-slot runs are common; the rest is writes, removes,
  // test fires, searches and the odd unknown mode.
  function automatic request_t random_request();
    request_t q;
    int       pick;
    int       s;
    int       b;
    q           = '0;
    q.entry     = 27'($urandom());
    q.dow       = ($urandom_range(19) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
    q.hour      = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
    q.minute    = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
    q.day_count = 16'($urandom());
    q.slot      = 4'($urandom_range(SLOTS - 1));
    pick        = $urandom_range(99);
    if (pick < 35) begin
      q.mode = MODE_TICK;
      if ($urandom_range(3) != 0) begin
        s = $urandom_range(SLOTS - 1);
        if (sb.in_use[s] && sb.entry[s].days != 7'd0) begin
          b = $urandom_range(6);
          while (!sb.entry[s].days[b]) b = (b + 1) % 7;
          q.dow    = 3'(b + 1);
          q.hour   = sb.entry[s].hour;
          q.minute = sb.entry[s].minute;
        end
      end
      // mostly reuse the running date so repeats hit the stamp guard
      if ($urandom_range(19) != 0) begin
        if ($urandom_range(4) == 0) dc_base++;
        q.day_count = dc_base;
      end
    end else if (pick < 65) begin
      q.mode          = MODE_WRITE;
      q.entry.enabled = ($urandom_range(4) != 0);
      q.entry.days    = $urandom_range(1) ? 7'($urandom_range(127)) : 7'(1 << $urandom_range(6));
      if ($urandom_range(1)) begin
        // shared times give multi-slot firings and search ties
        q.entry.hour   = 5'(6 + 6 * $urandom_range(2));
        q.entry.minute = 6'(30 * $urandom_range(1));
      end else begin
        q.entry.hour   = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
        q.entry.minute = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
      end
    end else if (pick < 73) begin
      q.mode = MODE_REMOVE;
    end else if (pick < 83) begin
      q.mode = MODE_TEST;
    end else if (pick < 95) begin
      q.mode = MODE_QUERY;
    end else begin
      q.mode = 3'($urandom_range(7, 5));
    end
    return q;
  endfunction

  // Unknown modes do nothing, so they do not count towards n.
  task automatic run_random(int n);
    request_t q;
    int       done;
    done = 0;
    while (done < n) begin
      q = random_request();
      send(q);
      if (q.mode <= MODE_QUERY) done++;
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender rarely idles, receiver mostly stalls.
    set_idling(8, 73);

    // Directed part under reset settings (quiet window off).
    send(mk(MODE_QUERY, 3'd1, 5'd12, 6'd0, 16'd0, 4'd0));           // empty table
    send(wr(4'd0, 1'b1, 7'h7F, 5'd23, 6'd59, 1'b1, 7'd127));        // every day, loud
    send(wr(4'd15, 1'b1, 7'h01, 5'd0, 6'd0, 1'b0, 7'd100));         // Monday midnight
    send(wr(4'd7, 1'b0, 7'h40, 5'd7, 6'd0, 1'b1, 7'd0));            // disabled
    send(wr(4'd3, 1'b1, 7'h00, 5'd31, 6'd63, 1'b1, 7'd101));        // no days, odd time
    send(mk(MODE_TICK, 3'd1, 5'd0, 6'd0, 16'd0, 4'd0));             // top slot fires
    send(wr(4'd15, 1'b1, 7'h01, 5'd0, 6'd0, 1'b0, 7'd100));         // rewrite keeps stamp
    send(mk(MODE_TICK, 3'd1, 5'd0, 6'd0, 16'd0, 4'd0));             // same minute: silent
    send(mk(MODE_TICK, 3'd0, 5'd23, 6'd59, 16'd5, 4'd0));           // bad weekday
    send(mk(MODE_TICK, 3'd7, 5'd23, 6'd59, 16'hFFFF, 4'd0));        // last date, Sunday
    send(mk(MODE_TEST, 3'd1, 5'd8, 6'd0, 16'd0, 4'd7));             // disabled still fires
    send(mk(MODE_TEST, 3'd1, 5'd8, 6'd0, 16'd0, 4'd5));             // free slot: silent
    send(mk(MODE_TEST, 3'd1, 5'd8, 6'd0, 16'd0, 4'd3));             // volume clamps
    send(mk(MODE_QUERY, 3'd1, 5'd23, 6'd59, 16'd0, 4'd0));          // current minute is past
    send(mk(MODE_QUERY, 3'd0, 5'd1, 6'd0, 16'd0, 4'd0));            // bad weekday
    send(mk(MODE_QUERY, 3'd7, 5'd23, 6'd59, 16'd0, 4'd0));          // wraps into Monday
    send(mk(MODE_REMOVE, 3'd1, 5'd0, 6'd0, 16'd0, 4'd15));
    send(mk(MODE_REMOVE, 3'd1, 5'd0, 6'd0, 16'd0, 4'd15));          // already free
    send(mk(MODE_TICK, 3'd1, 5'd0, 6'd0, 16'd1, 4'd0));             // removed: silent
    send(mk(3'd5, 3'd1, 5'd0, 6'd0, 16'd0, 4'd0));
    send(mk(3'd6, 3'd2, 5'd1, 6'd1, 16'd1, 4'd1));
    send(mk(3'd7, 3'd3, 5'd2, 6'd2, 16'd2, 4'd2));
    send(wr(4'd2, 1'b1, 7'h7F, 5'd23, 6'd59, 1'b1, 7'd50));
    send(wr(4'd9, 1'b1, 7'h7F, 5'd23, 6'd59, 1'b0, 7'd64));
    send(mk(MODE_TICK, 3'd2, 5'd23, 6'd59, 16'd7, 4'd0));           // three in slot order
    send(mk(MODE_QUERY, 3'd1, 5'd31, 6'd63, 16'd0, 4'd0));          // time beyond the day
    drain();

    // Quiet window wrapping past midnight, as after reset but switched on.
    set_config(1'b1, 1'b1, QUIET_START_RST, QUIET_END_RST);
    run_random(90);
    drain();

    // Back-pressure: fill every slot with one time, stall the receiver for a long
    // stretch and keep offering ticks that each fire the whole table.
    for (int s = 0; s < SLOTS; s++)
      send(wr(4'(s), 1'b1, 7'h7F, 5'd6, 6'd15, 1'(s), 7'(88 + 2 * s)));
    drain();
    hold_results(400);
    for (int k = 0; k < 4; k++)
      send(mk(MODE_TICK, 3'(k + 1), 5'd6, 6'd15, 16'(900 + k), 4'd0));
    send(mk(MODE_QUERY, 3'd1, 5'd6, 6'd14, 16'd0, 4'd0));           // tie: lowest slot
    drain();

    // Global enable off: ticks must stay silent.
    set_config(1'b0, 1'b1, QUIET_START_RST, QUIET_END_RST);
    run_random(15);
    drain();

    // Phase two: sender mostly idles, receiver rarely stalls.
    set_idling(73, 8);
    set_config(1'b1, 1'b1, 11'd0, 11'd1439);                        // whole day but last minute
    run_random(100);
    drain();
    set_config(1'b1, 1'b1, 11'd700, 11'd700);                       // empty window
    run_random(20);
    drain();

    // Phase three: no idling on either side.
    set_idling(0, 0);
    set_config(1'b1, 1'b1, 11'd1439, 11'd0);                        // wraps, last minute only
    run_random(100);
    drain();

    $display("Covered %0d requests: %0d slot firings, %0d next events, %0d empty searches,",
             sb.requests, sb.firings, sb.events, sb.empties);
    $display("with %0d register writes over wrapping, plain, empty and disabled quiet windows.",
             cfg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== weekly_alarm_table_core.f =====
rtl/walt_pkg.sv
rtl/weekly_alarm_table_core.sv
tb/weekly_alarm_table_core_tb.sv
